>>> sv/mf3_pkg.sv
package mf3_pkg;

  // Field and counter widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned ROW_W     = 13;
  localparam int unsigned EMIT_W    = 24;
  localparam int unsigned PROD_W    = 27;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned WIN_N     = 9;

  // Register reset values and height limit
  localparam int unsigned W_RESET    = 640;
  localparam int unsigned H_RESET    = 480;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 neighborhood, entry row*3+col, outside cells already zeroed
  typedef pix_t [WIN_N-1:0] win_t;

  // Input stage contents for one request
  typedef struct packed {
    pix_t pix;
    logic par;
    logic produce;
    logic last;
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } stage_a_t;

endpackage

>>> sv/mf3_ram.sv
module mf3_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                  clk_i,
  input  logic [AW-1:0]         addr_i,
  input  logic                  re_i,
  input  logic                  we_i,
  input  mf3_pkg::pix_t         wdata_i,
  output mf3_pkg::pix_t         rdata_o
);

  mf3_pkg::pix_t mem_q [DEPTH];
  mf3_pkg::pix_t rdata_q;

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mf3_median.sv
module mf3_median (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_last_i,
  input  mf3_pkg::win_t  in_win_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mf3_pkg::pix_t  out_median_o,
  output logic           out_last_o
);

  function automatic mf3_pkg::pix_t max2(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t min2(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t med3(mf3_pkg::pix_t a, mf3_pkg::pix_t b,
                                         mf3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Stage 1: each window row sorted (lo, mid, hi)
  mf3_pkg::win_t s1_d, s1_q;
  logic          s1_valid_q, s1_last_q;
  // Stage 2: max of lows, median of mids, min of highs
  mf3_pkg::pix_t s2_lo_d, s2_mid_d, s2_hi_d;
  mf3_pkg::pix_t s2_lo_q, s2_mid_q, s2_hi_q;
  logic          s2_valid_q, s2_last_q;
  // Output register
  mf3_pkg::pix_t out_med_q;
  logic          out_valid_q, out_last_q;

  logic out_en, s2_en, s1_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // Row sorters
  always_comb begin
    for (int y = 0; y < 3; y++) begin
      s1_d[3*y]   = min2(min2(in_win_i[3*y], in_win_i[3*y+1]), in_win_i[3*y+2]);
      s1_d[3*y+1] = med3(in_win_i[3*y], in_win_i[3*y+1], in_win_i[3*y+2]);
      s1_d[3*y+2] = max2(max2(in_win_i[3*y], in_win_i[3*y+1]), in_win_i[3*y+2]);
    end
  end

  // Column reduction
  always_comb begin
    s2_lo_d  = max2(max2(s1_q[0], s1_q[3]), s1_q[6]);
    s2_mid_d = med3(s1_q[1], s1_q[4], s1_q[7]);
    s2_hi_d  = min2(min2(s1_q[2], s1_q[5]), s1_q[8]);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_q      <= s1_d;
      s1_last_q <= in_last_i;
    end
    if (s2_en) begin
      s2_lo_q   <= s2_lo_d;
      s2_mid_q  <= s2_mid_d;
      s2_hi_q   <= s2_hi_d;
      s2_last_q <= s1_last_q;
    end
    if (out_en) begin
      out_med_q  <= med3(s2_lo_q, s2_mid_q, s2_hi_q);
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_median_o = out_med_q;
  assign out_last_o   = out_last_q;

endmodule

>>> sv/median_filter_3x3_core.sv
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+-----------------------
// config   | cfg_we_i, cfg_idx_i, cfg_data_i           | write on cfg_we_i
// input    | pixel_value_i, flush_i                    | in_valid_i/in_ready_o
// output   | median_value_o, frame_last_o              | out_valid_o/out_ready_i
//
// One request per cycle while in_ready_o is high. The request that completes a
// neighborhood passes the input stage, row sort, column reduction and output
// register, which offers its result. The line store is two single-port banks,
// each with one read and one write per cycle, so no request waits on memory.
// Reset clears counters and window at once; the line store has no clear pass.
// in_ready_o drops only while the output register holds an untaken result and
// every stage behind it is full.
module median_filter_3x3_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mf3_pkg::DIM_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mf3_pkg::PIX_W-1:0]            pixel_value_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mf3_pkg::PIX_W-1:0]            median_value_o,
  output logic                                 frame_last_o
);

  localparam int unsigned AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned DW      = mf3_pkg::DIM_W;
  localparam int unsigned EW      = mf3_pkg::DIM_W + 1;
  localparam int unsigned PW      = mf3_pkg::PROD_W;
  localparam int unsigned CW      = mf3_pkg::COL_W;
  localparam int unsigned RW      = mf3_pkg::ROW_W;
  localparam int unsigned XW      = mf3_pkg::EMIT_W;
  localparam int unsigned RstEffW = (mf3_pkg::W_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                  : mf3_pkg::W_RESET;
  localparam logic [EW-1:0] MaxW  = EW'(MAX_WIDTH);
  localparam logic [DW-1:0] MaxH  = DW'(mf3_pkg::MAX_HEIGHT);
  localparam logic [DW-1:0] WRst  = DW'(mf3_pkg::W_RESET);
  localparam logic [DW-1:0] HRst  = DW'(mf3_pkg::H_RESET);
  localparam logic [PW-1:0] WhRst = PW'(RstEffW * mf3_pkg::H_RESET);

  // Width in use: zero counts as one, clamp to the store depth
  function automatic logic [EW-1:0] eff_w(input logic [DW-1:0] v);
    logic [EW-1:0] x;
    x = {1'b0, v};
    if (v == '0) begin
      x = EW'(1);
    end else if (x > MaxW) begin
      x = MaxW;
    end
    return x;
  endfunction

  // Height in use: zero counts as one, clamp to the height limit
  function automatic logic [DW-1:0] eff_h(input logic [DW-1:0] v);
    logic [DW-1:0] x;
    x = v;
    if (v == '0) begin
      x = DW'(1);
    end else if (v > MaxH) begin
      x = MaxH;
    end
    return x;
  endfunction

  // Configuration
  logic [DW-1:0] w_d, w_q, h_d, h_q;
  logic [PW-1:0] wh_d, wh_q, ew_x, eh_x;
  logic          restart;
  logic [EW-1:0] cur_w;
  logic [DW-1:0] cur_h;

  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mf3_pkg::REG_IMAGE_WIDTH: begin
          w_d     = cfg_data_i;
          restart = 1'b1;
        end
        mf3_pkg::REG_IMAGE_HEIGHT: begin
          h_d     = cfg_data_i;
          restart = 1'b1;
        end
        default: ;
      endcase
    end
    ew_x = PW'(eff_w(w_d));
    eh_x = PW'(eff_h(h_d));
    wh_d = ew_x * eh_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= WRst;
      h_q  <= HRst;
      wh_q <= WhRst;
    end else if (cfg_we_i) begin
      w_q  <= w_d;
      h_q  <= h_d;
      wh_q <= wh_d;
    end
  end

  assign cur_w = eff_w(w_q);
  assign cur_h = eff_h(h_q);

  // Position counters and handshake
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d, row_m1;
  logic [XW-1:0] emit_q, emit_d;
  logic [CW:0]   col_inc;
  logic          accept, take, ignore;
  logic          a_valid_q, a_en, m_ready, move;
  mf3_pkg::stage_a_t a_d, a_q;

  assign a_en       = !a_valid_q || m_ready;
  assign in_ready_o = a_en;
  assign accept     = in_valid_i && in_ready_o;
  assign ignore     = flush_i && (row_q == '0) && (col_q == '0);
  assign take       = accept && !ignore;
  assign move       = a_valid_q && m_ready;

  // Request decode: pixel, output decision and border flags
  always_comb begin
    row_m1    = row_q - RW'(1);
    col_inc   = {1'b0, col_q} + (CW+1)'(1);
    a_d.par   = row_q[0];
    a_d.pix   = (flush_i || (row_q >= cur_h)) ? '0 : pixel_value_i;
    a_d.produce = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    a_d.last  = a_d.produce && ((PW'(emit_q) + PW'(1)) >= wh_q);
    a_d.top   = (col_q != '0) ? (row_q == RW'(1)) : (row_q == RW'(2));
    a_d.bot   = (col_q != '0) ? (row_q >= cur_h) : (row_m1 >= cur_h);
    a_d.lft   = (col_q == CW'(1)) || ((col_q == '0) && (cur_w == EW'(1)));
    a_d.rgt   = (col_q == '0) || (EW'(col_q) >= cur_w);

    col_d  = col_q;
    row_d  = row_q;
    emit_d = emit_q;
    if (take) begin
      if (a_d.last) begin
        col_d  = '0;
        row_d  = '0;
        emit_d = '0;
      end else begin
        if (a_d.produce) begin
          emit_d = emit_q + XW'(1);
        end
        if (EW'(col_inc) >= cur_w) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      emit_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (restart) begin
        col_q  <= '0;
        row_q  <= '0;
        emit_q <= '0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        emit_q <= emit_d;
      end
      if (a_en) begin
        a_valid_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_q <= a_d;
    end
  end

  // Line store: bank per row parity, both read at the current column
  logic [AW-1:0] addr;
  mf3_pkg::pix_t rd0, rd1;

  assign addr = AW'(col_q);

  mf3_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_bank0 (
    .clk_i   (clk_i),
    .addr_i  (addr),
    .re_i    (take),
    .we_i    (take && !row_q[0]),
    .wdata_i (a_d.pix),
    .rdata_o (rd0)
  );

  mf3_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_bank1 (
    .clk_i   (clk_i),
    .addr_i  (addr),
    .re_i    (take),
    .we_i    (take && row_q[0]),
    .wdata_i (a_d.pix),
    .rdata_o (rd1)
  );

  // Window shift and border masking
  mf3_pkg::pix_t [2:0][2:0] win_q, win_d;
  mf3_pkg::pix_t [2:0]      col_in;
  mf3_pkg::win_t            m_win;

  always_comb begin
    col_in[0] = a_q.par ? rd1 : rd0;
    col_in[1] = a_q.par ? rd0 : rd1;
    col_in[2] = a_q.pix;
    for (int y = 0; y < 3; y++) begin
      win_d[y][0] = win_q[y][1];
      win_d[y][1] = win_q[y][2];
      win_d[y][2] = col_in[y];
      for (int x = 0; x < 3; x++) begin
        if ((y == 0 && a_q.top) || (y == 2 && a_q.bot) ||
            (x == 0 && a_q.lft) || (x == 2 && a_q.rgt)) begin
          m_win[3*y+x] = '0;
        end else begin
          m_win[3*y+x] = win_d[y][x];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart) begin
      win_q <= '0;
    end else if (move) begin
      win_q <= (a_q.produce && a_q.last) ? '0 : win_d;
    end
  end

  // Median network and output register
  mf3_median u_median (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (a_valid_q && a_q.produce),
    .in_ready_o   (m_ready),
    .in_last_i    (a_q.last),
    .in_win_i     (m_win),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_median_o (median_value_o),
    .out_last_o   (frame_last_o)
  );

endmodule

>>> sv/mf3_checker.sv
module mf3_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [mf3_pkg::PIX_W-1:0] median_value_o,
  input logic                      frame_last_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(median_value_o) && $stable(frame_last_o))
    else $error("stalled result changed or dropped");

  // No result is offered in the cycle after a reset cycle
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // An empty or draining output stage never blocks a request
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("request blocked with output free");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .median_value_o (median_value_o),
  .frame_last_o   (frame_last_o)
);
